FILE: design/bra_pkg.sv
// bra_pkg: shared types, codes and constants of the bitmap run allocator
// no dependencies; compiled first

package bra_pkg;

    localparam int ACT_W     = 3;
    localparam int LEN_W     = 13;
    localparam int IDX_W     = 12;
    localparam int CFG_W     = 7;

    localparam int WORDS_DEF     = 64;
    localparam int WORD_BITS_DEF = 64;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [ACT_W-1:0] ACT_ALLOC    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NEXT_ZERO = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NEXT_ONE = 3'd4;

    typedef enum logic [1:0] {
        PH_FIND = 2'd0,
        PH_FILL = 2'd1,
        PH_SCAN = 2'd2
    } t_phase;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SEEK  = 5'b00100,
        ST_RD    = 5'b01000,
        ST_EX    = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic seek_step;
        logic rd;
        logic ex;
        logic clr;
        logic reject;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic seek_done;
        logic ex_done;
        logic clr_done;
    } t_stat;

endpackage

FILE: design/bra_if.sv
// bra_in_if and bra_out_if: valid/ready channels for request and result beats
// depends on bra_pkg

interface bra_in_if;
    logic                       valid;
    logic                       ready;
    logic [bra_pkg::ACT_W-1:0]  action;
    logic [bra_pkg::LEN_W-1:0]  run_length;
    logic [bra_pkg::IDX_W-1:0]  first_index;
    logic [bra_pkg::IDX_W-1:0]  last_index;

    modport source (output valid, action, run_length, first_index, last_index,
                    input ready);
    modport sink   (input valid, action, run_length, first_index, last_index,
                    output ready);
endinterface

interface bra_out_if;
    logic                       valid;
    logic                       ready;
    logic [bra_pkg::IDX_W-1:0]  result_index;
    logic                       found;

    modport source (output valid, result_index, found, input ready);
    modport sink   (input valid, result_index, found, output ready);
endinterface

FILE: design/bra_ctrl.sv
// bra_ctrl: sequencing state machine of the allocator
// depends on bra_pkg; drives commands into bra_dp and reads its status

module bra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  bra_pkg::t_stat  i_stat,
    output bra_pkg::t_cmd   o_cmd
);

    bra_pkg::t_state r_state, n_state;
    logic            r_ovalid, n_ovalid;
    logic            can_fin;
    logic            fin;

    assign can_fin     = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == bra_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            bra_pkg::ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = bra_pkg::ST_IDLE;
                end
            end
            bra_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bra_pkg::ST_SEEK;
                end
            end
            bra_pkg::ST_SEEK: begin
                if (i_stat.bad) begin
                    if (can_fin) begin
                        o_cmd.reject = 1'b1;
                        n_state      = bra_pkg::ST_IDLE;
                    end
                end else if (i_stat.seek_done) begin
                    n_state = bra_pkg::ST_RD;
                end else begin
                    o_cmd.seek_step = 1'b1;
                end
            end
            bra_pkg::ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = bra_pkg::ST_EX;
            end
            bra_pkg::ST_EX: begin
                if (i_stat.ex_done) begin
                    if (can_fin) begin
                        o_cmd.ex = 1'b1;
                        n_state  = bra_pkg::ST_IDLE;
                    end
                end else begin
                    o_cmd.ex = 1'b1;
                    n_state  = bra_pkg::ST_RD;
                end
            end
            default: begin
                n_state = bra_pkg::ST_IDLE;
            end
        endcase
    end

    assign fin = o_cmd.reject || (o_cmd.ex && i_stat.ex_done);

    always_comb begin
        if (fin) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bra_pkg::ST_CLEAR;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

FILE: design/bra_dp.sv
// bra_dp: bitmap memory, word walk registers and per-word scan logic
// depends on bra_pkg; commanded by bra_ctrl

module bra_dp #(
    parameter int WORDS     = bra_pkg::WORDS_DEF,
    parameter int WORD_BITS = bra_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bra_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic [bra_pkg::ACT_W-1:0]   i_action,
    input  logic [bra_pkg::LEN_W-1:0]   i_run_length,
    input  logic [bra_pkg::IDX_W-1:0]   i_first_index,
    input  logic [bra_pkg::IDX_W-1:0]   i_last_index,
    input  bra_pkg::t_cmd               i_cmd,
    output bra_pkg::t_stat              o_stat,
    output logic [bra_pkg::IDX_W-1:0]   o_result_index,
    output logic                        o_found
);

    localparam int AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int EW  = $clog2(WORDS + 1);
    localparam int CW  = (EW > bra_pkg::CFG_W) ? EW : bra_pkg::CFG_W;
    localparam int BW  = $clog2(WORDS * WORD_BITS + 1);
    localparam int XW  = ((BW > bra_pkg::LEN_W) ? BW : bra_pkg::LEN_W) + 1;
    localparam int PW  = $clog2(WORD_BITS);
    localparam int LV  = PW;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    logic [bra_pkg::CFG_W-1:0]  r_wiu;
    logic [bra_pkg::ACT_W-1:0]  r_act;
    logic [bra_pkg::LEN_W-1:0]  r_n;
    bra_pkg::t_phase            r_phase;
    logic [XW-1:0]              r_lo, r_hi, r_base, r_carry, r_run_base, r_start;
    logic [AW-1:0]              r_word, r_run_word;
    logic                       r_pass, r_bad;
    logic [bra_pkg::IDX_W-1:0]  r_res;
    logic                       r_found;

    logic [CW-1:0] wiu_x, eff;
    logic [XW-1:0] total, base_end, lo_in, hi_in, n_x;
    logic          bad_in, last_word, fill_end;
    logic          ex_done;

    logic [WORD_BITS-1:0] f;
    logic                 has_l  [LV+1][WORD_BITS];
    logic [PW-1:0]        last_l [LV+1][WORD_BITS];
    logic [WORD_BITS-1:0] hit_v, scan_v, fill_m;
    logic                 run_hit, scan_hit, want, in_cur;
    logic [PW-1:0]        run_pos, scan_pos;
    logic [XW-1:0]        z, idx_p, run_start, run_end, scan_idx;
    logic [WORD_BITS-1:0] wr_data;
    logic                 wr_en;

    assign wiu_x    = CW'(r_wiu);
    assign eff      = (wiu_x > CW'(WORDS)) ? CW'(WORDS) : wiu_x;
    assign total    = XW'(eff) * XW'(WORD_BITS);
    assign base_end = r_base + XW'(WORD_BITS);
    assign lo_in    = XW'(i_first_index);
    assign hi_in    = XW'(i_last_index);
    assign n_x      = XW'(r_n);
    assign last_word = (CW'(r_word) + CW'(1)) == eff;
    assign fill_end  = base_end > r_hi;
    assign want      = (r_act == bra_pkg::ACT_NEXT_ONE);

    always_comb begin
        case (i_action)
            bra_pkg::ACT_ALLOC:     bad_in = (i_run_length == '0) || (lo_in >= total);
            bra_pkg::ACT_SET,
            bra_pkg::ACT_CLEAR:     bad_in = (lo_in > hi_in) || (hi_in >= total);
            bra_pkg::ACT_NEXT_ZERO,
            bra_pkg::ACT_NEXT_ONE:  bad_in = (lo_in >= total);
            default:                bad_in = 1'b1;
        endcase
    end

    // index order: position 0 is the msb of the word
    always_comb begin
        for (int p = 0; p < WORD_BITS; p++) begin
            f[p]         = r_rdata[WORD_BITS-1-p];
            has_l[0][p]  = r_rdata[WORD_BITS-1-p];
            last_l[0][p] = PW'(p);
        end
        for (int d = 0; d < LV; d++) begin
            for (int p = 0; p < WORD_BITS; p++) begin
                if (!has_l[d][p] && p >= (1 << d)) begin
                    has_l[d+1][p]  = has_l[d][(p >= (1 << d)) ? p - (1 << d) : 0];
                    last_l[d+1][p] = last_l[d][(p >= (1 << d)) ? p - (1 << d) : 0];
                end else begin
                    has_l[d+1][p]  = has_l[d][p];
                    last_l[d+1][p] = last_l[d][p];
                end
            end
        end
        for (int p = 0; p < WORD_BITS; p++) begin
            idx_p = r_base + XW'(p);
            if (has_l[LV][p]) begin
                z = XW'(p) - XW'(last_l[LV][p]);
            end else begin
                z = r_carry + XW'(p) + XW'(1);
            end
            hit_v[p]  = !f[p] && (z >= n_x);
            scan_v[p] = (f[p] == want) && (idx_p >= r_lo);
            fill_m[WORD_BITS-1-p] = (idx_p >= r_lo) && (idx_p <= r_hi);
        end
    end

    always_comb begin
        run_hit  = 1'b0;
        run_pos  = '0;
        scan_hit = 1'b0;
        scan_pos = '0;
        for (int p = WORD_BITS - 1; p >= 0; p--) begin
            if (hit_v[p]) begin
                run_hit = 1'b1;
                run_pos = PW'(p);
            end
            if (scan_v[p]) begin
                scan_hit = 1'b1;
                scan_pos = PW'(p);
            end
        end
    end

    assign run_end   = r_base + XW'(run_pos);
    assign run_start = run_end + XW'(1) - n_x;
    assign in_cur    = n_x <= (XW'(run_pos) + XW'(1));
    assign scan_idx  = r_base + XW'(scan_pos);

    always_comb begin
        case (r_phase)
            bra_pkg::PH_FIND: ex_done = !run_hit && last_word && r_pass;
            bra_pkg::PH_FILL: ex_done = fill_end;
            bra_pkg::PH_SCAN: ex_done = scan_hit || last_word;
            default:          ex_done = 1'b1;
        endcase
    end

    always_comb begin
        o_stat.bad       = r_bad;
        o_stat.seek_done = base_end > r_lo;
        o_stat.ex_done   = ex_done;
        o_stat.clr_done  = (r_word == AW'(WORDS - 1));
    end

    always_comb begin
        if (r_act == bra_pkg::ACT_CLEAR) begin
            wr_data = r_rdata & ~fill_m;
        end else begin
            wr_data = r_rdata | fill_m;
        end
        wr_en = i_cmd.ex && (r_phase == bra_pkg::PH_FILL);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_word] <= '0;
        end else if (wr_en) begin
            mem[r_word] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_word];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wiu  <= bra_pkg::CFG_RESET;
            r_word <= '0;
        end else begin
            if (i_cfg_we) begin
                r_wiu <= i_cfg_wdata;
            end
            if (i_cmd.clr || i_cmd.seek_step) begin
                r_word <= r_word + AW'(1);
            end else if (i_cmd.load) begin
                r_word <= '0;
            end else if (i_cmd.ex) begin
                case (r_phase)
                    bra_pkg::PH_FIND: begin
                        if (run_hit) begin
                            r_word <= in_cur ? r_word : r_run_word;
                        end else if (last_word) begin
                            r_word <= '0;
                        end else begin
                            r_word <= r_word + AW'(1);
                        end
                    end
                    default: begin
                        r_word <= r_word + AW'(1);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act      <= i_action;
            r_n        <= i_run_length;
            r_lo       <= lo_in;
            r_hi       <= hi_in;
            r_base     <= '0;
            r_carry    <= '0;
            r_run_word <= '0;
            r_run_base <= '0;
            r_pass     <= 1'b0;
            r_bad      <= bad_in;
            case (i_action)
                bra_pkg::ACT_ALLOC:               r_phase <= bra_pkg::PH_FIND;
                bra_pkg::ACT_SET, bra_pkg::ACT_CLEAR: r_phase <= bra_pkg::PH_FILL;
                default:                          r_phase <= bra_pkg::PH_SCAN;
            endcase
        end else if (i_cmd.seek_step) begin
            r_base <= base_end;
        end else if (i_cmd.ex) begin
            case (r_phase)
                bra_pkg::PH_FIND: begin
                    if (run_hit) begin
                        r_phase <= bra_pkg::PH_FILL;
                        r_lo    <= run_start;
                        r_hi    <= run_end;
                        r_start <= run_start;
                        r_base  <= in_cur ? r_base : r_run_base;
                    end else if (last_word) begin
                        r_base     <= '0;
                        r_carry    <= '0;
                        r_run_word <= '0;
                        r_run_base <= '0;
                        r_pass     <= 1'b1;
                    end else begin
                        r_base <= base_end;
                        if (!has_l[LV][WORD_BITS-1]) begin
                            r_carry <= r_carry + XW'(WORD_BITS);
                            if (r_carry == '0) begin
                                r_run_word <= r_word;
                                r_run_base <= r_base;
                            end
                        end else begin
                            r_carry    <= XW'(WORD_BITS - 1) - XW'(last_l[LV][WORD_BITS-1]);
                            r_run_word <= r_word;
                            r_run_base <= r_base;
                        end
                    end
                end
                default: begin
                    r_base <= base_end;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.reject) begin
            r_res   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.ex && ex_done) begin
            case (r_phase)
                bra_pkg::PH_FILL: begin
                    r_res   <= (r_act == bra_pkg::ACT_ALLOC) ? r_start[bra_pkg::IDX_W-1:0] : '0;
                    r_found <= 1'b1;
                end
                bra_pkg::PH_SCAN: begin
                    r_res   <= scan_hit ? scan_idx[bra_pkg::IDX_W-1:0] : '0;
                    r_found <= scan_hit;
                end
                default: begin
                    r_res   <= '0;
                    r_found <= 1'b0;
                end
            endcase
        end
    end

    assign o_result_index = r_res;
    assign o_found        = r_found;

endmodule

FILE: design/bitmap_run_allocator_unit.sv
// bitmap_run_allocator_unit: top level, ties bra_ctrl and bra_dp to the channels
// depends on bra_pkg, bra_in_if, bra_out_if, bra_ctrl, bra_dp
// a rejected beat is answered from the seek state; otherwise the seek state first
// skips the words before the start word, then each word is read from memory and
// then scanned or written back (one memory read, one scan or write-back per word)
// allocate may walk the span twice and then write the run
// one item at a time; the result register lets the next beat in while it waits
// after reset a clearing pass zeroes every word of the bitmap before any beat

module bitmap_run_allocator_unit #(
    parameter int WORDS     = bra_pkg::WORDS_DEF,
    parameter int WORD_BITS = bra_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bra_pkg::CFG_W-1:0]   i_cfg_wdata,
    bra_in_if.sink                      i_item,
    bra_out_if.source                   o_result
);

    bra_pkg::t_cmd  cmd;
    bra_pkg::t_stat stat;

    bra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bra_dp #(
        .WORDS     (WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_action       (i_item.action),
        .i_run_length   (i_item.run_length),
        .i_first_index  (i_item.first_index),
        .i_last_index   (i_item.last_index),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result_index (o_result.result_index),
        .o_found        (o_result.found)
    );

endmodule
